>>> sv/eft_pkg.sv
// ----------------------------------------------------------------------------
// eft_pkg
// Shared constants, codes and tables for the Euler frame transform.
// ----------------------------------------------------------------------------
package eft_pkg;

    localparam int DEF_CORDIC_STAGES = 24;
    localparam int MAX_STAGES        = 30;

    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 4;
    localparam int SEL_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd7;

    // free variable codes
    localparam logic [SEL_W-1:0] SEL_NONE  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_X     = 3'd1;
    localparam logic [SEL_W-1:0] SEL_Y     = 3'd2;
    localparam logic [SEL_W-1:0] SEL_Z     = 3'd3;
    localparam logic [SEL_W-1:0] SEL_ALPHA = 3'd4;
    localparam logic [SEL_W-1:0] SEL_BETA  = 3'd5;
    localparam logic [SEL_W-1:0] SEL_GAMMA = 3'd6;

    localparam logic [MODE_W-1:0] NUM_MODES = 4'd12;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [33:0] NEG_ONE_Q30 = -34'sd1073741824;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;

    typedef logic signed [33:0] q_t;   // internal wide Q2.30 / Q4.28 value

    function automatic q_t atan_q30(input int i);
        q_t r;
        case (i)
            0: r = 34'sd843314856;  1: r = 34'sd497837829;
            2: r = 34'sd263043836;  3: r = 34'sd133525158;
            4: r = 34'sd67021686;   5: r = 34'sd33543515;
            6: r = 34'sd16775850;   7: r = 34'sd8388437;
            8: r = 34'sd4194282;    9: r = 34'sd2097149;
            10: r = 34'sd1048575;   11: r = 34'sd524287;
            12: r = 34'sd262143;    13: r = 34'sd131071;
            14: r = 34'sd65535;     15: r = 34'sd32767;
            16: r = 34'sd16383;     17: r = 34'sd8191;
            18: r = 34'sd4095;      19: r = 34'sd2047;
            20: r = 34'sd1023;      21: r = 34'sd511;
            22: r = 34'sd255;       23: r = 34'sd127;
            24: r = 34'sd63;        25: r = 34'sd31;
            26: r = 34'sd15;        27: r = 34'sd7;
            28: r = 34'sd3;         29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // axis of rotation k (0..2) for a mode
    function automatic axis_t mode_axis(input logic [MODE_W-1:0] m, input int k);
        logic [5:0] a;
        case (m)
            4'd0: a = {2'd2, 2'd0, 2'd2};
            4'd1: a = {2'd0, 2'd1, 2'd0};
            4'd2: a = {2'd1, 2'd2, 2'd1};
            4'd3: a = {2'd2, 2'd1, 2'd2};
            4'd4: a = {2'd0, 2'd2, 2'd0};
            4'd5: a = {2'd1, 2'd0, 2'd1};
            4'd6: a = {2'd0, 2'd1, 2'd2};
            4'd7: a = {2'd1, 2'd2, 2'd0};
            4'd8: a = {2'd2, 2'd0, 2'd1};
            4'd9: a = {2'd0, 2'd2, 2'd1};
            4'd10: a = {2'd2, 2'd1, 2'd0};
            4'd11: a = {2'd1, 2'd0, 2'd2};
            default: a = '0;
        endcase
        case (k)
            0: return axis_t'(a[5:4]);
            1: return axis_t'(a[3:2]);
            default: return axis_t'(a[1:0]);
        endcase
    endfunction

    function automatic q_t clamp_one(input logic signed [65:0] v);
        if (v > 66'(ONE_Q30)) return ONE_Q30;
        if (v < 66'(NEG_ONE_Q30)) return NEG_ONE_Q30;
        return v[33:0];
    endfunction

    typedef q_t mat_t [3][3];

endpackage

>>> sv/eft_sincos.sv
// ----------------------------------------------------------------------------
// eft_sincos
// Pipelined sin/cos: range reduction stage, one CORDIC stage per register,
// sign fix and clamp stage. Side payload travels alongside.
// ----------------------------------------------------------------------------
module eft_sincos #(
    parameter int STAGES = eft_pkg::DEF_CORDIC_STAGES,
    parameter int TAG_W  = 1
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [31:0]      angle [3],
    input  logic [TAG_W-1:0]        tag_in,
    output eft_pkg::q_t             sin_o [3],
    output eft_pkg::q_t             cos_o [3],
    output logic [TAG_W-1:0]        tag_out
);
    import eft_pkg::*;

    localparam int NS = (STAGES < MAX_STAGES) ? STAGES : MAX_STAGES;

    q_t          x_reg [NS+1][3];
    q_t          y_reg [NS+1][3];
    q_t          z_reg [NS+1][3];
    logic        neg_reg [NS+1][3];
    logic [TAG_W-1:0] tag_reg [NS+1];

    // range reduction
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                automatic q_t a = 34'(angle[k]);
                automatic logic n = 1'b0;
                if (a > PI_Q28) a = a - TWO_PI_Q28;
                if (a < -PI_Q28) a = a + TWO_PI_Q28;
                if (a > HALF_PI_Q28) begin
                    a = a - PI_Q28;
                    n = 1'b1;
                end else if (a < -HALF_PI_Q28) begin
                    a = a + PI_Q28;
                    n = 1'b1;
                end
                x_reg[0][k]   <= GAIN_Q30;
                y_reg[0][k]   <= '0;
                z_reg[0][k]   <= a <<< 2;
                neg_reg[0][k] <= n;
            end
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    if (!z_reg[i][k][33]) begin
                        x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] - atan_q30(i);
                    end else begin
                        x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] + atan_q30(i);
                    end
                    neg_reg[i+1][k] <= neg_reg[i][k];
                end
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (neg_reg[NS][k]) begin
                    cos_o[k] <= clamp_one(-66'(x_reg[NS][k]));
                    sin_o[k] <= clamp_one(-66'(y_reg[NS][k]));
                end else begin
                    cos_o[k] <= clamp_one(66'(x_reg[NS][k]));
                    sin_o[k] <= clamp_one(66'(y_reg[NS][k]));
                end
            end
            tag_out <= tag_reg[NS];
        end
    end

endmodule

>>> sv/euler_frame_transform.sv
// ----------------------------------------------------------------------------
// euler_frame_transform
// Homogeneous pose of one robot frame from a base pose and one joint value.
// ----------------------------------------------------------------------------
// One request in, one pose out, a new request every cycle unless the output
// stalls. Pipeline (CORDIC stages capped at 30): a capture stage, a
// range reduction stage, one stage per CORDIC iteration, a sign/clamp stage,
// matrix build, and two stages for each of the two 3x3 products (multiply,
// then sum/round/clamp); the last sum stage is the output register.
// The whole pipe advances when the output is empty or taken.
// Configuration must only be written while no request is in flight.
module euler_frame_transform #(
    parameter int CORDIC_STAGES = eft_pkg::DEF_CORDIC_STAGES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_joint_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_rot_00,
    output logic signed [31:0]            m_rot_01,
    output logic signed [31:0]            m_rot_02,
    output logic signed [31:0]            m_rot_10,
    output logic signed [31:0]            m_rot_11,
    output logic signed [31:0]            m_rot_12,
    output logic signed [31:0]            m_rot_20,
    output logic signed [31:0]            m_rot_21,
    output logic signed [31:0]            m_rot_22,
    output logic signed [31:0]            m_trans_x,
    output logic signed [31:0]            m_trans_y,
    output logic signed [31:0]            m_trans_z
);
    import eft_pkg::*;

    localparam int NS  = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int LAT = NS + 8;   // stages including output register
    // tag: spare bit (tied low), identity flag, axes, translation
    localparam int TAG_W = 1 + 1 + 6 + 96;

    logic [MODE_W-1:0]  mode_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic signed [31:0] base_reg [6];

    logic en;
    logic [LAT-1:0] vld_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            sel_reg  <= '0;
            for (int k = 0; k < 6; k++) base_reg[k] <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:  mode_reg    <= cfg_data[MODE_W-1:0];
                REG_SEL:   sel_reg     <= cfg_data[SEL_W-1:0];
                REG_X:     base_reg[0] <= cfg_data;
                REG_Y:     base_reg[1] <= cfg_data;
                REG_Z:     base_reg[2] <= cfg_data;
                REG_ALPHA: base_reg[3] <= cfg_data;
                REG_BETA:  base_reg[4] <= cfg_data;
                REG_GAMMA: base_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[LAT-2:0], s_valid};
    end

    // capture stage: substitute the free variable
    logic signed [31:0] val_reg [6];
    logic               ident_reg;
    logic [5:0]         axes_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                val_reg[k] <= (sel_reg == SEL_NONE || sel_reg > SEL_GAMMA ||
                               sel_reg != SEL_W'(k + 1)) ? base_reg[k] : s_joint_value;
            end
            ident_reg <= (mode_reg >= NUM_MODES);
            axes_reg  <= {mode_axis(mode_reg, 0), mode_axis(mode_reg, 1),
                          mode_axis(mode_reg, 2)};
        end
    end

    logic signed [31:0] ang [3];
    assign ang[0] = val_reg[3];
    assign ang[1] = val_reg[4];
    assign ang[2] = val_reg[5];

    q_t               sn [3];
    q_t               cs [3];
    logic [TAG_W-1:0] tag_o;

    eft_sincos #(.STAGES(CORDIC_STAGES), .TAG_W(TAG_W)) u_sincos (
        .aclk    (aclk),
        .en      (en),
        .angle   (ang),
        .tag_in  ({1'b0, ident_reg, axes_reg, val_reg[0], val_reg[1], val_reg[2]}),
        .sin_o   (sn),
        .cos_o   (cs),
        .tag_out (tag_o)
    );

    // build the three elementary rotations
    mat_t r1_reg, r2_reg, r3_reg;
    logic [TAG_W-1:0] tb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                automatic mat_t m;
                automatic logic [1:0] r = tag_o[101 - 2*k -: 2];
                // the two mixed axes, in cyclic order after r
                automatic logic [1:0] p = (r == 2'd2) ? 2'd0 : r + 2'd1;
                automatic logic [1:0] q = (r == 2'd0) ? 2'd2 : r - 2'd1;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        m[i][j] = (i == j) ? ONE_Q30 : '0;
                m[p][p] = cs[k];
                m[p][q] = -sn[k];
                m[q][p] = sn[k];
                m[q][q] = cs[k];
                if (k == 0) r1_reg <= m;
                else if (k == 1) r2_reg <= m;
                else r3_reg <= m;
            end
            tb_reg <= tag_o;
        end
    end

    // product 1: multiply stage then sum stage
    logic signed [65:0] p1_reg [3][3][3];
    mat_t r3a_reg, t_reg, r3b_reg;
    logic [TAG_W-1:0] tp1_reg, tt_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        p1_reg[i][j][k] <= 66'(r1_reg[i][k]) * 66'(r2_reg[k][j]);
            r3a_reg <= r3_reg;
            tp1_reg <= tb_reg;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    t_reg[i][j] <= clamp_one((p1_reg[i][j][0] + p1_reg[i][j][1] +
                                              p1_reg[i][j][2] + 66'sd536870912) >>> 30);
            r3b_reg <= r3a_reg;
            tt_reg  <= tp1_reg;
        end
    end

    // product 2
    logic signed [65:0] p2_reg [3][3][3];
    mat_t rot_reg;
    logic [TAG_W-1:0] tp2_reg, tr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        p2_reg[i][j][k] <= 66'(t_reg[i][k]) * 66'(r3b_reg[k][j]);
            tp2_reg <= tt_reg;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    if (tp2_reg[102])
                        rot_reg[i][j] <= (i == j) ? ONE_Q30 : '0;
                    else
                        rot_reg[i][j] <= clamp_one((p2_reg[i][j][0] + p2_reg[i][j][1] +
                                                    p2_reg[i][j][2] + 66'sd536870912) >>> 30);
                end
            tr_reg <= tp2_reg;
        end
    end

    assign m_rot_00  = rot_reg[0][0][31:0];
    assign m_rot_01  = rot_reg[0][1][31:0];
    assign m_rot_02  = rot_reg[0][2][31:0];
    assign m_rot_10  = rot_reg[1][0][31:0];
    assign m_rot_11  = rot_reg[1][1][31:0];
    assign m_rot_12  = rot_reg[1][2][31:0];
    assign m_rot_20  = rot_reg[2][0][31:0];
    assign m_rot_21  = rot_reg[2][1][31:0];
    assign m_rot_22  = rot_reg[2][2][31:0];
    assign m_trans_x = tr_reg[95:64];
    assign m_trans_y = tr_reg[63:32];
    assign m_trans_z = tr_reg[31:0];

endmodule

>>> sv/eft_checker.sv
// ----------------------------------------------------------------------------
// eft_checker
// Port-level checks on the frame transform, bound to the top level.
// ----------------------------------------------------------------------------
module eft_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_rot_00,
    input logic signed [31:0] m_rot_11,
    input logic signed [31:0] m_rot_22
);
    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rot_00))
        else $error("result changed while stalled");

    // input is taken whenever the output side is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // the last two diagonal entries stay within unit range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rot_11 <= 32'sd1073741824 && m_rot_11 >= -32'sd1073741824 &&
                     m_rot_22 <= 32'sd1073741824 && m_rot_22 >= -32'sd1073741824))
        else $error("rotation entry out of range");

    // nothing out right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result after reset");
endmodule

bind euler_frame_transform eft_checker u_eft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_rot_00 (m_rot_00),
    .m_rot_11 (m_rot_11),
    .m_rot_22 (m_rot_22)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for euler_frame_transform: directed table of poses,
// then random configuration phases and joint streams, each result compared
// against a typed row's pose or a bench-side CORDIC/matrix pose predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import eft_pkg::*;

    localparam int STAGES    = DEF_CORDIC_STAGES;
    localparam int HANG_MAX  = 3000;
    localparam int PHASES    = 34;
    localparam int PER_PHASE = 50;

    typedef enum logic [3:0] {
        M_ZXZ, M_XYX, M_YZY, M_ZYZ, M_XZX, M_YXY,
        M_XYZ, M_YZX, M_ZXY, M_XZY, M_ZYX, M_YXZ,
        M_BAD12, M_BAD13, M_BAD14, M_BAD15
    } euler_mode_t;

    localparam logic [SEL_W-1:0] SEL_BAD = 3'd7;

    typedef logic [0:11][31:0] pose_t;
    typedef longint mat3_t [3][3];

    typedef struct {
        euler_mode_t       mode;
        logic [SEL_W-1:0]  sel;
        int                x, y, z, al, be, ga;
        int                joint;
        bit                typed;      // expectation given in the row
        int                ex, ey, ez;
    } pose_row_t;

    localparam longint ATAN_Q30 [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1
    };

    localparam int EULER_AXES [12][3] = '{
        '{2,0,2}, '{0,1,0}, '{1,2,1}, '{2,1,2}, '{0,2,0}, '{1,0,1},
        '{0,1,2}, '{1,2,0}, '{2,0,1}, '{0,2,1}, '{2,1,0}, '{1,0,2}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [31:0]   s_joint_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [31:0]   m_rot_00, m_rot_01, m_rot_02;
    logic signed [31:0]   m_rot_10, m_rot_11, m_rot_12;
    logic signed [31:0]   m_rot_20, m_rot_21, m_rot_22;
    logic signed [31:0]   m_trans_x, m_trans_y, m_trans_z;

    logic [31:0] reg_shadow [8];
    pose_t       pose_q [$];
    int          errors = 0;
    int          stall_cnt = 0;
    bit          quiet = 0;

    always #10 aclk = ~aclk;

    euler_frame_transform #(.CORDIC_STAGES(STAGES)) i_dut (.*);

    // ---------------- predictor ----------------
    function automatic longint sat_unit(input longint v);
        if (v > longint'(ONE_Q30)) return longint'(ONE_Q30);
        if (v < -longint'(ONE_Q30)) return -longint'(ONE_Q30);
        return v;
    endfunction

    function automatic void cordic_sincos(input longint ang, output longint s,
                                          output longint c);
        longint a, x, y, z, nx;
        bit flip;
        a = ang;
        flip = 0;
        x = longint'(GAIN_Q30);
        y = 0;
        if (a > longint'(PI_Q28)) a -= longint'(TWO_PI_Q28);
        if (a < -longint'(PI_Q28)) a += longint'(TWO_PI_Q28);
        if (a > longint'(HALF_PI_Q28)) begin
            a -= longint'(PI_Q28);
            flip = 1;
        end else if (a < -longint'(HALF_PI_Q28)) begin
            a += longint'(PI_Q28);
            flip = 1;
        end
        z = a * 4;
        for (int i = 0; i < STAGES && i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_Q30[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_Q30[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = sat_unit(x);
        s = sat_unit(y);
    endfunction

    function automatic mat3_t axis_rotation(input int ax, input longint ang);
        mat3_t m;
        longint s, c;
        int p, q;
        cordic_sincos(ang, s, c);
        p = (ax + 1) % 3;
        q = (ax + 2) % 3;
        foreach (m[i, j]) m[i][j] = (i == j) ? longint'(ONE_Q30) : 0;
        m[p][p] = c;
        m[p][q] = -s;
        m[q][p] = s;
        m[q][q] = c;
        return m;
    endfunction

    function automatic mat3_t mat3_mul(input mat3_t a, input mat3_t b);
        mat3_t o;
        longint acc;
        foreach (o[i, j]) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
            o[i][j] = sat_unit((acc + (longint'(1) << 29)) >>> 30);
        end
        return o;
    endfunction

    function automatic pose_t pose_predict(input logic [31:0] joint);
        longint val [6];
        mat3_t  rot;
        pose_t  p;
        int     sel, mode;
        for (int i = 0; i < 6; i++) val[i] = longint'($signed(reg_shadow[2+i]));
        sel  = reg_shadow[REG_SEL][SEL_W-1:0];
        mode = reg_shadow[REG_MODE][MODE_W-1:0];
        if (sel >= SEL_X && sel <= SEL_GAMMA) val[sel-1] = longint'($signed(joint));
        if (mode < NUM_MODES) begin
            rot = mat3_mul(mat3_mul(axis_rotation(EULER_AXES[mode][0], val[3]),
                                    axis_rotation(EULER_AXES[mode][1], val[4])),
                           axis_rotation(EULER_AXES[mode][2], val[5]));
        end else begin
            foreach (rot[i, j]) rot[i][j] = (i == j) ? longint'(ONE_Q30) : 0;
        end
        foreach (rot[i, j]) p[i*3+j] = rot[i][j][31:0];
        for (int i = 0; i < 3; i++) p[9+i] = val[i][31:0];
        return p;
    endfunction

    function automatic pose_t unit_pose(input int ex, input int ey, input int ez);
        pose_t p;
        foreach (p[i]) p[i] = '0;
        p[0] = ONE_Q30[31:0];
        p[4] = ONE_Q30[31:0];
        p[8] = ONE_Q30[31:0];
        p[9] = ex;
        p[10] = ey;
        p[11] = ez;
        return p;
    endfunction

    // ---------------- drivers ----------------
    // leaves cfg_valid high; caller drops it after the last write
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MODE: reg_shadow[idx] = v & 32'hF;
            REG_SEL:  reg_shadow[idx] = v & 32'h7;
            default:  reg_shadow[idx] = v;
        endcase
    endtask

    task automatic load_pose_regs(input logic [31:0] mode, input logic [31:0] sel,
                                  input int x, input int y, input int z,
                                  input int al, input int be, input int ga);
        reg_write(REG_MODE, mode);
        reg_write(REG_SEL, sel);
        reg_write(REG_X, x);
        reg_write(REG_Y, y);
        reg_write(REG_Z, z);
        reg_write(REG_ALPHA, al);
        reg_write(REG_BETA, be);
        reg_write(REG_GAMMA, ga);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_joint(input logic [31:0] v, input bit typed, input pose_t want);
        s_valid       <= 1'b1;
        s_joint_value <= v;
        do @(posedge aclk); while (!s_ready);
        pose_q.push_back(typed ? want : pose_predict(v));
        if (!quiet && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word(input bit angle);
        case ($urandom_range(11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return angle ? PI_Q28[31:0] + $urandom_range(2) - 1 : 32'hFFFF_FFFF;
            4: return angle ? -HALF_PI_Q28[31:0] + $urandom_range(2) - 1 : 32'h1;
            5: return angle ? HALF_PI_Q28[31:0] + $urandom_range(2) - 1 : 32'h0001_0000;
            6: return $signed(32'(PI_Q28)) * -1 - $urandom_range(1);
            default: return $urandom;
        endcase
    endfunction

    // ---------------- result checking ----------------
    always @(posedge aclk) begin
        pose_t got, want;
        got = {m_rot_00, m_rot_01, m_rot_02, m_rot_10, m_rot_11, m_rot_12,
               m_rot_20, m_rot_21, m_rot_22, m_trans_x, m_trans_y, m_trans_z};
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
        if (aresetn && m_valid && m_ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected pose, rot_00 %0d", $time, $signed(got[0]));
                errors++;
            end else begin
                want = pose_q.pop_front();
                for (int i = 0; i < 12; i++)
                    if (got[i] !== want[i]) begin
                        $display("%0t: field %0d expected %0d actual %0d", $time, i,
                                 $signed(want[i]), $signed(got[i]));
                        errors++;
                    end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == HANG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    pose_row_t pose_tab [18];

    initial begin
        pose_t none_pose;
        logic [31:0] mode, sel;
        foreach (reg_shadow[i]) reg_shadow[i] = '0;
        none_pose = unit_pose(0, 0, 0);
        pose_tab = '{
            '{M_ZXZ, SEL_NONE, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0},
            '{M_BAD12, SEL_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 1, 123456789,
              -5, 843314857, 5, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1},
            '{M_BAD15, SEL_X, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 32'h8000_0000, 0, 0},
            '{M_BAD13, SEL_Y, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 0, 32'h7FFF_FFFF, 0},
            '{M_BAD14, SEL_Z, 0, 0, 0, 7, 8, 9, -1, 1, 0, 0, -1},
            '{M_ZXZ, SEL_ALPHA, 32'h18000, -5, 32'h7FFF_FFFF, 0, 32'h1000_0000,
              -32'h1000_0000, 843314857, 0, 0, 0, 0},
            '{M_XYX, SEL_ALPHA, 1, 2, 3, 0, 300000000, 5, 843314858, 0, 0, 0, 0},
            '{M_YZY, SEL_BETA, 1, 2, 3, 100, 0, -200, -843314857, 0, 0, 0, 0},
            '{M_ZYZ, SEL_BETA, 1, 2, 3, -100, 0, 200, -843314858, 0, 0, 0, 0},
            '{M_XZX, SEL_GAMMA, 1, 2, 3, 500000000, -500000000, 0, 421657428, 0, 0, 0, 0},
            '{M_YXY, SEL_GAMMA, 1, 2, 3, 1, 1, 0, 421657429, 0, 0, 0, 0},
            '{M_XYZ, SEL_ALPHA, 1, 2, 3, 0, 421657428, 421657429, -421657429, 0, 0, 0, 0},
            '{M_YZX, SEL_BETA, 1, 2, 3, -421657428, 0, 9, 32'h7FFF_FFFF, 0, 0, 0, 0},
            '{M_ZXY, SEL_GAMMA, 1, 2, 3, 77, 88, 0, 32'h8000_0000, 0, 0, 0, 0},
            '{M_XZY, SEL_X, 1, 2, 3, 32'h7FFF_FFFF, 32'h8000_0000, 300000000, 12345,
              0, 0, 0, 0},
            '{M_ZYX, SEL_NONE, 1, 2, 3, -421657428, 421657428, 843314857, 99, 0, 0, 0, 0},
            '{M_YXZ, SEL_GAMMA, -1, -2, -3, 400000000, -400000000, 0, 0, 0, 0, 0, 0},
            '{M_XYZ, SEL_BAD, 4, 5, 6, 1, 2, 3, 7, 0, 0, 0, 0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first row runs on reset values, the rest reload every register
        foreach (pose_tab[r]) begin
            if (r != 0)
                load_pose_regs(pose_tab[r].mode, pose_tab[r].sel, pose_tab[r].x,
                               pose_tab[r].y, pose_tab[r].z, pose_tab[r].al,
                               pose_tab[r].be, pose_tab[r].ga);
            send_joint(pose_tab[r].joint, pose_tab[r].typed,
                       unit_pose(pose_tab[r].ex, pose_tab[r].ey, pose_tab[r].ez));
            drain();
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            quiet = (ph >= 10 && ph < 16);
            mode = ($urandom_range(99) < 85) ? $urandom_range(11) : $urandom_range(15);
            sel  = $urandom_range(7);
            if (ph == 0)
                load_pose_regs(M_YXZ, SEL_GAMMA, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else if (ph == 1)
                load_pose_regs(M_ZXZ, SEL_X, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            else
                load_pose_regs(mode, sel, pick_word(0), pick_word(0), pick_word(0),
                               pick_word(1), pick_word(1), pick_word(1));
            for (int n = 0; n < PER_PHASE; n++)
                send_joint(pick_word(reg_shadow[REG_SEL] >= SEL_ALPHA), 0, none_pose);
            drain();
        end

        repeat (STAGES + 20) @(posedge aclk);
        if (errors == 0 && pose_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
